/* hw/rtl/rqsr_pkg.sv */
// Shared types, codes and the sequencer control store for the ring queue.
package rqsr_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned FILL_W = 4;

   typedef enum logic [1:0] {
      CMD_PUSH   = 2'd0,
      CMD_POP    = 2'd1,
      CMD_SEARCH = 2'd2,
      CMD_REMOVE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Sequencer step addresses
   typedef enum logic [4:0] {
      S_IDLE,
      S_PUSH_CHK,
      S_PUSH_WR,
      S_POP_RD,
      S_POP_TAKE,
      S_SCAN_INIT,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SCAN_END,
      S_FOUND,
      S_SHIFT_TEST,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_REMOVE,
      S_RSP_EMPTY,
      S_RSP_FULL,
      S_RESPOND
   } step_type;

   // Datapath actions
   typedef enum logic [3:0] {
      A_NONE,
      A_ACCEPT,
      A_PUSH,
      A_RD_HEAD,
      A_POP,
      A_K_LOAD,
      A_SCAN_RD,
      A_FOUND,
      A_RD_NEXT,
      A_SHIFT_WR,
      A_REMOVE,
      A_ST_EMPTY,
      A_ST_FULL,
      A_RESPOND
   } act_type;

   // Branch conditions
   typedef enum logic [3:0] {
      J_ALWAYS,
      J_DISPATCH,
      J_FULL,
      J_EMPTY,
      J_MISS_MORE,
      J_NO_MATCH,
      J_SEARCH,
      J_SHIFT_DONE,
      J_SHIFT_MORE,
      J_OUT_BUSY
   } cond_type;

   typedef struct packed {
      act_type  act;
      cond_type cond;
      step_type on_true;
      step_type on_false;
   } uword_type;

   // Control store: one word per step
   function automatic uword_type ucode(input step_type s);
      uword_type w;
      unique case (s)
         S_IDLE:       w = '{A_ACCEPT,   J_DISPATCH,   S_IDLE,       S_IDLE};
         S_PUSH_CHK:   w = '{A_NONE,     J_FULL,       S_RSP_FULL,   S_PUSH_WR};
         S_PUSH_WR:    w = '{A_PUSH,     J_ALWAYS,     S_RESPOND,    S_RESPOND};
         S_POP_RD:     w = '{A_RD_HEAD,  J_EMPTY,      S_RSP_EMPTY,  S_POP_TAKE};
         S_POP_TAKE:   w = '{A_POP,      J_ALWAYS,     S_RESPOND,    S_RESPOND};
         S_SCAN_INIT:  w = '{A_K_LOAD,   J_EMPTY,      S_RSP_EMPTY,  S_SCAN_RD};
         S_SCAN_RD:    w = '{A_SCAN_RD,  J_ALWAYS,     S_SCAN_CMP,   S_SCAN_CMP};
         S_SCAN_CMP:   w = '{A_NONE,     J_MISS_MORE,  S_SCAN_RD,    S_SCAN_END};
         S_SCAN_END:   w = '{A_NONE,     J_NO_MATCH,   S_RESPOND,    S_FOUND};
         S_FOUND:      w = '{A_FOUND,    J_SEARCH,     S_RESPOND,    S_SHIFT_TEST};
         S_SHIFT_TEST: w = '{A_NONE,     J_SHIFT_DONE, S_REMOVE,     S_SHIFT_RD};
         S_SHIFT_RD:   w = '{A_RD_NEXT,  J_ALWAYS,     S_SHIFT_WR,   S_SHIFT_WR};
         S_SHIFT_WR:   w = '{A_SHIFT_WR, J_SHIFT_MORE, S_SHIFT_RD,   S_REMOVE};
         S_REMOVE:     w = '{A_REMOVE,   J_ALWAYS,     S_RESPOND,    S_RESPOND};
         S_RSP_EMPTY:  w = '{A_ST_EMPTY, J_ALWAYS,     S_RESPOND,    S_RESPOND};
         S_RSP_FULL:   w = '{A_ST_FULL,  J_ALWAYS,     S_RESPOND,    S_RESPOND};
         S_RESPOND:    w = '{A_RESPOND,  J_OUT_BUSY,   S_RESPOND,    S_IDLE};
         default:      w = '{A_NONE,     J_ALWAYS,     S_IDLE,       S_IDLE};
      endcase
      return w;
   endfunction

   // Entry step for each command
   function automatic step_type dispatch(input cmd_type c);
      step_type s;
      unique case (c)
         CMD_PUSH:   s = S_PUSH_CHK;
         CMD_POP:    s = S_POP_RD;
         CMD_SEARCH: s = S_SCAN_INIT;
         CMD_REMOVE: s = S_SCAN_INIT;
         default:    s = S_IDLE;
      endcase
      return s;
   endfunction

endpackage

/* hw/rtl/rqsr_if.sv */
// Valid/ready channel interfaces for the command and response words.
interface rqsr_req_if import rqsr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   cmd_type                  cmd;
   logic signed [WORD_W-1:0] operand;

   modport source (output valid, output cmd, output operand, input ready);
   modport sink (input valid, input cmd, input operand, output ready);
endinterface

interface rqsr_rsp_if import rqsr_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] popped_word;
   logic                     found;
   status_type               status;
   logic [FILL_W-1:0]        fill_count;

   modport source (output valid, output popped_word, output found, output status,
                   output fill_count, input ready);
   modport sink (input valid, input popped_word, input found, input status,
                 input fill_count, output ready);
endinterface

/* hw/rtl/rqsr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rqsr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/ring_queue_search_remove_core.sv */
// Top level: circular word queue with search and remove, microcoded control.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  req     | in  | req.valid/req.ready  | cmd, operand
//  rsp     | out | rsp.valid/rsp.ready  | popped_word, found, status, fill_count
//
// Search and remove scan the stored words from the newest end; a remove on a hit
// then moves each later word down one slot to close the gap.
// The scan and shift rate is set by the single RAM read port: one read per scanned
// or moved word, with the compare or write-back in the cycle after it.
// Reset (synchronous) empties the queue; the slot RAM needs no clearing pass.
// One word in flight; the response register lets the next command enter while
// the previous response still waits on rsp.ready.
module ring_queue_search_remove_core import rqsr_pkg::*; #(
   parameter int unsigned DEPTH = 16
) (
   input logic          clock,
   input logic          reset,
   rqsr_req_if.sink     req,
   rqsr_rsp_if.source   rsp
);

   localparam int unsigned PW = $clog2(DEPTH);
   localparam int unsigned CW = (PW > FILL_W) ? PW : FILL_W;
   localparam logic [PW-1:0] FULL_COUNT = PW'(DEPTH - 1);

   // (a + b) mod DEPTH for a, b below DEPTH
   function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                              input logic [PW-1:0] b);
      logic [PW:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= (PW+1)'(DEPTH)) begin
         s = s - (PW+1)'(DEPTH);
      end
      return s[PW-1:0];
   endfunction

   // Sequencer
   step_type  upc_ff, upc_in;
   uword_type uw;
   logic      cond_true;

   // Command registers
   cmd_type                  cmd_ff, cmd_in;
   logic signed [WORD_W-1:0] operand_ff, operand_in;

   // Queue state
   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] tail_ff, tail_in;
   logic [PW-1:0] count_ff, count_in;
   logic [PW-1:0] k_ff, k_in;      // scan position, logical from head
   logic [PW-1:0] j_ff, j_in;      // shift position

   // Result being built
   logic signed [WORD_W-1:0] popped_ff, popped_in;
   logic                     found_ff, found_in;
   status_type               status_ff, status_in;

   // Response register
   logic                     out_valid_ff, out_valid_in;
   logic signed [WORD_W-1:0] out_popped_ff, out_popped_in;
   logic                     out_found_ff, out_found_in;
   status_type               out_status_ff, out_status_in;
   logic [FILL_W-1:0]        out_fill_ff, out_fill_in;

   // RAM port
   logic              ram_we, ram_re;
   logic [PW-1:0]     ram_waddr, ram_raddr;
   logic [WORD_W-1:0] ram_wdata, ram_rdata;

   logic          req_accept;
   logic          out_busy;
   logic          match;
   logic [PW-1:0] k_dec;
   logic [PW:0]   j_plus1, j_plus2;
   logic [CW-1:0] count_wide;

   rqsr_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign uw         = ucode(upc_ff);
   // no word is taken while reset is held
   assign req.ready  = (uw.act == A_ACCEPT) && !reset;
   assign req_accept = req.valid && req.ready;
   assign out_busy   = out_valid_ff && !rsp.ready;
   assign match      = (ram_rdata == operand_ff);
   assign k_dec      = k_ff - PW'(1);
   assign j_plus1    = {1'b0, j_ff} + (PW+1)'(1);
   assign j_plus2    = {1'b0, j_ff} + (PW+1)'(2);
   assign count_wide = CW'(count_ff);

   // Branch condition and next step
   always_comb begin
      unique case (uw.cond)
         J_ALWAYS:     cond_true = 1'b1;
         J_DISPATCH:   cond_true = req.valid;
         J_FULL:       cond_true = (count_ff == FULL_COUNT);
         J_EMPTY:      cond_true = (count_ff == '0);
         J_MISS_MORE:  cond_true = !match && (k_ff != '0);
         J_NO_MATCH:   cond_true = !match;
         J_SEARCH:     cond_true = (cmd_ff == CMD_SEARCH);
         J_SHIFT_DONE: cond_true = (j_plus1 >= {1'b0, count_ff});
         J_SHIFT_MORE: cond_true = (j_plus2 < {1'b0, count_ff});
         J_OUT_BUSY:   cond_true = out_busy;
         default:      cond_true = 1'b0;
      endcase

      if (uw.cond == J_DISPATCH && cond_true) begin
         upc_in = dispatch(req.cmd);
      end else if (cond_true) begin
         upc_in = uw.on_true;
      end else begin
         upc_in = uw.on_false;
      end
   end

   // Datapath
   always_comb begin
      cmd_in        = cmd_ff;
      operand_in    = operand_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      popped_in     = popped_ff;
      found_in      = found_ff;
      status_in     = status_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      out_popped_in = out_popped_ff;
      out_found_in  = out_found_ff;
      out_status_in = out_status_ff;
      out_fill_in   = out_fill_ff;
      ram_we        = 1'b0;
      ram_waddr     = tail_ff;
      ram_wdata     = operand_ff;
      ram_re        = 1'b0;
      ram_raddr     = head_ff;

      unique case (uw.act)
         A_NONE: begin
         end
         A_ACCEPT: begin
            if (req_accept) begin
               cmd_in     = req.cmd;
               operand_in = req.operand;
               popped_in  = '0;
               found_in   = 1'b0;
               status_in  = ST_OK;
            end
         end
         A_PUSH: begin
            ram_we   = 1'b1;
            tail_in  = wrap_add(tail_ff, PW'(1));
            count_in = count_ff + PW'(1);
         end
         A_RD_HEAD: begin
            ram_re = 1'b1;
         end
         A_POP: begin
            popped_in = ram_rdata;
            head_in   = wrap_add(head_ff, PW'(1));
            count_in  = count_ff - PW'(1);
         end
         A_K_LOAD: begin
            k_in = count_ff;
         end
         A_SCAN_RD: begin
            // newest first: step back one and fetch
            k_in      = k_dec;
            ram_re    = 1'b1;
            ram_raddr = wrap_add(head_ff, k_dec);
         end
         A_FOUND: begin
            found_in = 1'b1;
            j_in     = k_ff;
         end
         A_RD_NEXT: begin
            ram_re    = 1'b1;
            ram_raddr = wrap_add(head_ff, j_plus1[PW-1:0]);
         end
         A_SHIFT_WR: begin
            ram_we    = 1'b1;
            ram_waddr = wrap_add(head_ff, j_ff);
            ram_wdata = ram_rdata;
            j_in      = j_plus1[PW-1:0];
         end
         A_REMOVE: begin
            tail_in  = wrap_add(tail_ff, FULL_COUNT);
            count_in = count_ff - PW'(1);
         end
         A_ST_EMPTY: begin
            status_in = ST_EMPTY;
         end
         A_ST_FULL: begin
            status_in = ST_FULL;
         end
         A_RESPOND: begin
            if (!out_busy) begin
               out_valid_in  = 1'b1;
               out_popped_in = popped_ff;
               out_found_in  = found_ff;
               out_status_in = status_ff;
               out_fill_in   = count_wide[FILL_W-1:0];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff       <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         upc_ff       <= upc_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      operand_ff    <= operand_in;
      k_ff          <= k_in;
      j_ff          <= j_in;
      popped_ff     <= popped_in;
      found_ff      <= found_in;
      status_ff     <= status_in;
      out_popped_ff <= out_popped_in;
      out_found_ff  <= out_found_in;
      out_status_ff <= out_status_in;
      out_fill_ff   <= out_fill_in;
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.popped_word = out_popped_ff;
   assign rsp.found       = out_found_ff;
   assign rsp.status      = out_status_ff;
   assign rsp.fill_count  = out_fill_ff;

`ifndef SYNTHESIS
   // pointers and count stay consistent
   a_ptr_count: assert property (@(posedge clock) disable iff (reset)
      tail_ff == wrap_add(head_ff, count_ff))
      else $error("tail pointer disagrees with head plus count");

   // a push always grows the queue by one word
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (uw.act == A_PUSH) |=> (count_ff == $past(count_ff) + PW'(1)))
      else $error("push did not advance count");

   // full status only reported with a full queue
   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (uw.act == A_RESPOND && !out_busy && status_ff == ST_FULL)
         |-> (count_ff == FULL_COUNT))
      else $error("full status on a queue that is not full");

   // a match is never reported alongside an error status
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (uw.act == A_RESPOND && !out_busy && found_ff) |-> (status_ff == ST_OK))
      else $error("found set with non-ok status");
`endif

endmodule
